FILE: sv/rgbhsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rgbhsi_pkg;

    localparam int STEPS    = 24;
    localparam int ZW       = 29;
    localparam int XY_SHIFT = 20;
    localparam int QW       = 17;

    localparam logic signed [ZW-1:0] ANG_PI      = 29'sd52707179;
    localparam logic signed [ZW-1:0] ANG_TWO_PI  = 29'sd105414357;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 29'sd26353589;
    localparam logic [20:0]          SQRT3_Q20   = 21'd1816187;
    localparam logic [15:0]          GRAY_HUE    = 16'd25736;
    localparam logic [16:0]          SAT_ONE     = 17'd65536;

    typedef struct packed {
        logic gray;
        logic mirror;
        logic black;
    } side_t;

    // arctan(2^-k) in 2^-24 rad
    function automatic logic signed [ZW-1:0] atan_step(input int k);
        logic signed [ZW-1:0] a;
        case (k)
            0:       a = 29'sd13176795;
            1:       a = 29'sd7778716;
            2:       a = 29'sd4110060;
            3:       a = 29'sd2086331;
            4:       a = 29'sd1047214;
            5:       a = 29'sd524117;
            6:       a = 29'sd262123;
            7:       a = 29'sd131069;
            default: a = ZW'(29'sd1 <<< (24 - k));
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

FILE: sv/rgb_to_hsi_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: front end, setup, 24 CORDIC stages, output.
// Throughput: one pixel per cycle when not stalled; every stage has its own valid bit register.
// The divider for saturation retires one quotient bit per CORDIC stage in the first 17 stages.
// Stall: m_tready low with m_tvalid high freezes the pipe; s_tready follows the output register.
// Reset: rst_n asynchronous active low clears all valid bits; payload is not reset.
module rgb_to_hsi_converter #(
    parameter int COMPONENT_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // red, green, blue (COMPONENT_BITS each), zero pad to bytes
    input  wire logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // hue[15:0], saturation[32:16], intensity[48:33], zero pad
    output logic [55:0] m_tdata
);
    import rgbhsi_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int SW = CB + 2;              // component sum
    localparam int DW = CB + 3;              // divisor 2*sum
    localparam int NW = CB + 20;             // dividend 6*min*2^16 + sum
    localparam int XW = CB + 26;             // CORDIC x/y
    localparam int MW = CB + 10;             // sum*256+1
    localparam int RK = MW + 1;              // reciprocal shift for /3
    localparam int PW = MW + RK;
    localparam logic [RK-1:0] RECIP = RK'(((64'd1 << RK) + 64'd2) / 64'd3);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- front end: sum, min, differences
    logic [CB-1:0] r_in, g_in, b_in;
    assign r_in = s_tdata[CB-1:0];
    assign g_in = s_tdata[2*CB-1:CB];
    assign b_in = s_tdata[3*CB-1:2*CB];

    logic                 v1_reg;
    logic [SW-1:0]        sum1_reg, sum1_next;
    logic [CB-1:0]        mn1_reg, mn1_next;
    logic [CB-1:0]        ad1_reg, ad1_next;
    logic signed [CB+2:0] xs1_reg, xs1_next;
    side_t                side1_reg, side1_next;

    always_comb
    begin
        sum1_next = SW'(r_in) + SW'(g_in) + SW'(b_in);
        mn1_next  = r_in;
        if (g_in < mn1_next)
        begin
            mn1_next = g_in;
        end
        if (b_in < mn1_next)
        begin
            mn1_next = b_in;
        end
        ad1_next = (g_in >= b_in) ? (g_in - b_in) : (b_in - g_in);
        xs1_next = $signed({2'b00, r_in, 1'b0}) - $signed({3'b000, g_in})
                 - $signed({3'b000, b_in});
        side1_next.gray   = (r_in == g_in) && (g_in == b_in);
        side1_next.mirror = b_in > g_in;
        side1_next.black  = sum1_next == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum1_reg  <= sum1_next;
            mn1_reg   <= mn1_next;
            ad1_reg   <= ad1_next;
            xs1_reg   <= xs1_next;
            side1_reg <= side1_next;
        end
    end

    // ---------------- pipeline arrays; index 0 is setup, k+1 is after step k
    logic                 vld_reg  [0:STEPS];
    logic signed [XW-1:0] x_reg    [0:STEPS];
    logic signed [XW-1:0] y_reg    [0:STEPS];
    logic signed [ZW-1:0] z_reg    [0:STEPS];
    logic [DW-1:0]        rem_reg  [0:STEPS];
    logic [DW-1:0]        dsr_reg  [0:STEPS];
    logic [QW-1:0]        nlo_reg  [0:STEPS];
    logic [QW-1:0]        q_reg    [0:STEPS];
    side_t                side_reg [0:STEPS];
    logic [15:0]          inten_reg[1:STEPS];
    logic [PW-1:0]        prod_reg;

    // setup stage: scale, sqrt(3) product, pre-rotation, divider and /3 setup
    logic signed [XW-1:0] x0_next, y0_next, xa, ya;
    logic signed [ZW-1:0] z0_next;
    logic [NW-1:0]        n0;
    logic [MW-1:0]        m0;

    always_comb
    begin
        xa = XW'(xs1_reg) <<< XY_SHIFT;
        ya = $signed(XW'(ad1_reg) * XW'(SQRT3_Q20));
        if (xa < 0)
        begin
            x0_next = ya;
            y0_next = -xa;
            z0_next = ANG_HALF_PI;
        end
        else
        begin
            x0_next = xa;
            y0_next = ya;
            z0_next = '0;
        end
        n0 = (NW'(mn1_reg) * NW'(6) << 16) + NW'(sum1_reg);
        m0 = {MW'(sum1_reg) << 8} + MW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            rem_reg[0]  <= n0[NW-1:QW];
            nlo_reg[0]  <= n0[QW-1:0];
            q_reg[0]    <= '0;
            dsr_reg[0]  <= {sum1_reg, 1'b0};
            side_reg[0] <= side1_reg;
            prod_reg    <= PW'(m0) * PW'(RECIP);
        end
    end

    // step logic: CORDIC rotation and one restoring-division bit per stage for the first QW stages
    logic signed [XW-1:0] x_next  [0:STEPS-1];
    logic signed [XW-1:0] y_next  [0:STEPS-1];
    logic signed [ZW-1:0] z_next  [0:STEPS-1];
    logic [DW-1:0]        rem_next[0:STEPS-1];
    logic [QW-1:0]        nlo_next[0:STEPS-1];
    logic [QW-1:0]        q_next  [0:STEPS-1];
    logic [15:0]          inten0;
    logic [PW-RK-1:0]     quot3;

    always_comb
    begin
        logic signed [XW-1:0] xsh, ysh;
        logic [DW:0]          t;
        for (int k = 0; k < STEPS; k++)
        begin
            xsh = x_reg[k] >>> k;
            ysh = y_reg[k] >>> k;
            if (y_reg[k] >= 0)
            begin
                x_next[k] = x_reg[k] + ysh;
                y_next[k] = y_reg[k] - xsh;
                z_next[k] = z_reg[k] + atan_step(k);
            end
            else
            begin
                x_next[k] = x_reg[k] - ysh;
                y_next[k] = y_reg[k] + xsh;
                z_next[k] = z_reg[k] - atan_step(k);
            end
            t = {rem_reg[k], nlo_reg[k][QW-1]};
            if (k < QW)
            begin
                nlo_next[k] = nlo_reg[k] << 1;
                if (t >= {1'b0, dsr_reg[k]})
                begin
                    rem_next[k] = DW'(t - {1'b0, dsr_reg[k]});
                    q_next[k]   = {q_reg[k][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k] = DW'(t);
                    q_next[k]   = {q_reg[k][QW-2:0], 1'b0};
                end
            end
            else
            begin
                nlo_next[k] = nlo_reg[k];
                rem_next[k] = rem_reg[k];
                q_next[k]   = q_reg[k];
            end
        end
        quot3  = prod_reg[PW-1:RK];
        inten0 = (quot3 > (PW-RK)'(16'hFFFF)) ? 16'hFFFF : quot3[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= v1_reg;
            for (int k = 0; k < STEPS; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                x_reg[k+1]    <= x_next[k];
                y_reg[k+1]    <= y_next[k];
                z_reg[k+1]    <= z_next[k];
                rem_reg[k+1]  <= rem_next[k];
                nlo_reg[k+1]  <= nlo_next[k];
                q_reg[k+1]    <= q_next[k];
                dsr_reg[k+1]  <= dsr_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
            inten_reg[1] <= inten0;
            for (int k = 1; k < STEPS; k++)
            begin
                inten_reg[k+1] <= inten_reg[k];
            end
        end
    end

    // ---------------- output: clamp, mirror, round to Q3.13
    logic                 out_vld_reg;
    logic [55:0]          out_reg, out_next;
    logic signed [ZW-1:0] zc, za, zr;
    logic [15:0]          hue;
    logic [16:0]          sat;

    always_comb
    begin
        zc = z_reg[STEPS];
        if (zc < 0)
        begin
            zc = '0;
        end
        if (zc > ANG_PI)
        begin
            zc = ANG_PI;
        end
        za  = side_reg[STEPS].mirror ? (ANG_TWO_PI - zc) : zc;
        zr  = za + ZW'(1024);
        hue = side_reg[STEPS].gray ? GRAY_HUE : zr[26:11];
        sat = side_reg[STEPS].black ? SAT_ONE : (SAT_ONE - q_reg[STEPS]);
        out_next = {7'b0, inten_reg[STEPS], sat, hue};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire

FILE: sv/rgbhsi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rgbhsi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);

    // held beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // a stalled full output blocks the input
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:0] <= 16'd51472 && m_tdata[32:16] <= 17'd65536)
        else $error("hue or saturation out of range");

    a_rst: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind rgb_to_hsi_converter rgbhsi_checker u_rgbhsi_checker (.*);
`default_nettype wire
